### rtl/rotation_matrix_to_quaternion_unit_assert.svh
// Assertion macros shared by the rotation matrix to quaternion checker
`ifndef ROTATION_MATRIX_TO_QUATERNION_UNIT_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_UNIT_ASSERT_SVH

// Implication checked outside reset
`define RMQ_ASSERT_IMPL(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("rmq: implication failed");

// Stalled valid holds, payload unchanged, on the next edge
`define RMQ_ASSERT_HOLD(label, clk, rst_n, vld, rdy, data) \
	label: assert property (@(posedge clk) disable iff (!rst_n) \
		((vld) && !(rdy)) |=> ((vld) && $stable(data))) \
		else $error("rmq: stalled item changed");

// Condition checked at every edge, reset included
`define RMQ_ASSERT_ALWAYS(label, clk, cond) \
	label: assert property (@(posedge clk) (cond)) \
		else $error("rmq: invariant failed");

`endif

### rtl/rmq_pkg.sv
// Types and constants of the rotation matrix to quaternion unit
`timescale 1ns / 1ps

package rmq_pkg;

	localparam int DATA_WIDTH = 16;
	localparam int FRAC_BITS  = 14;

	localparam int TR_W     = DATA_WIDTH + 2;
	localparam int RAD_W    = DATA_WIDTH + 3;
	localparam int RAD_U_W  = DATA_WIDTH + 1;
	localparam int SQ_STEPS = (RAD_U_W + FRAC_BITS + 1) / 2;
	localparam int N2_W     = 2 * SQ_STEPS;
	localparam int ROOT_W   = SQ_STEPS;
	localparam int REM_W    = ROOT_W + 1;
	localparam int DIFF_W   = DATA_WIDTH + 1;
	localparam int MAG_W    = DIFF_W;
	localparam int NUM_W    = MAG_W + FRAC_BITS;
	localparam int DEN_W    = ROOT_W + 1;
	localparam int QUO_W    = NUM_W - FRAC_BITS / 2 - 1;
	localparam int N_DIV    = 3;

	typedef enum logic [1:0] {
		SLOT_W = 2'd0,
		SLOT_X = 2'd1,
		SLOT_Y = 2'd2,
		SLOT_Z = 2'd3
	} slot_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] m00;
		logic signed [DATA_WIDTH-1:0] m01;
		logic signed [DATA_WIDTH-1:0] m02;
		logic signed [DATA_WIDTH-1:0] m10;
		logic signed [DATA_WIDTH-1:0] m11;
		logic signed [DATA_WIDTH-1:0] m12;
		logic signed [DATA_WIDTH-1:0] m20;
		logic signed [DATA_WIDTH-1:0] m21;
		logic signed [DATA_WIDTH-1:0] m22;
	} mat_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] qw;
		logic signed [DATA_WIDTH-1:0] qx;
		logic signed [DATA_WIDTH-1:0] qy;
		logic signed [DATA_WIDTH-1:0] qz;
	} quat_t;

	typedef logic signed [DIFF_W-1:0] diff_t;

	// Slot that takes s/2, and the three dividends for the other slots in ascending order
	typedef struct packed {
		slot_t                          slot;
		logic [N_DIV-1:0][DIFF_W-1:0]   d;
	} side_t;

endpackage

### rtl/rotation_matrix_to_quaternion_unit.sv
// Rotation matrix to unit quaternion converter, fully pipelined
`timescale 1ns / 1ps

// Converts a 3x3 rotation matrix (signed Q2.14) into the quaternion w, x, y, z (signed
// Q2.14, saturated) by Shepperd's method. One item is taken every cycle while the pipeline
// advances. The pipeline depth is set by the square root, which resolves one root bit
// per stage (16 stages), and by the three dividers that run side by side and resolve one
// quotient bit per stage (23 stages). The whole pipeline advances whenever the output
// register is empty or being taken, so mat_ready follows quat_ready combinationally.
module rotation_matrix_to_quaternion_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           mat_valid,
	output logic           mat_ready,
	input  rmq_pkg::mat_t  mat,
	output logic           quat_valid,
	input  logic           quat_ready,
	output rmq_pkg::quat_t quat
);
	import rmq_pkg::*;

	localparam logic signed [RAD_W-1:0] RAD_ONE  = RAD_W'(64'(1) << FRAC_BITS);
	localparam logic [QUO_W-1:0]        POS_LIM  = QUO_W'((64'(1) << (DATA_WIDTH - 1)) - 1);
	localparam logic [QUO_W-1:0]        NEG_LIM  = QUO_W'(64'(1) << (DATA_WIDTH - 1));

	function automatic diff_t dsub(input logic signed [DATA_WIDTH-1:0] a,
			input logic signed [DATA_WIDTH-1:0] b);
		return diff_t'(a) - diff_t'(b);
	endfunction

	function automatic diff_t dadd(input logic signed [DATA_WIDTH-1:0] a,
			input logic signed [DATA_WIDTH-1:0] b);
		return diff_t'(a) + diff_t'(b);
	endfunction

	function automatic logic [DATA_WIDTH-1:0] sat_q(input logic neg,
			input logic [QUO_W-1:0] q);
		logic [DATA_WIDTH-1:0] r;
		if (!neg) begin
			r = (q > POS_LIM) ? DATA_WIDTH'(POS_LIM) : q[DATA_WIDTH-1:0];
		end else begin
			r = (q > NEG_LIM) ? DATA_WIDTH'(NEG_LIM) : (~q[DATA_WIDTH-1:0]) + 1'b1;
		end
		return r;
	endfunction

	logic advance;
	logic out_valid_q;
	quat_t out_q;

	assign advance    = !out_valid_q || quat_ready;
	assign mat_ready  = advance;
	assign quat_valid = out_valid_q;
	assign quat       = out_q;

	// Stage 1: trace sign and largest diagonal entry
	logic signed [TR_W-1:0] tr_c;
	slot_t                  slot_c;
	logic                   valid_s1;
	mat_t                   mat_s1;
	slot_t                  slot_s1;

	always_comb begin
		tr_c = TR_W'(mat.m00) + TR_W'(mat.m11) + TR_W'(mat.m22);
		if (tr_c > 0) begin
			slot_c = SLOT_W;
		end else if (mat.m22 > ((mat.m11 > mat.m00) ? mat.m11 : mat.m00)) begin
			slot_c = SLOT_Z;
		end else if (mat.m11 > mat.m00) begin
			slot_c = SLOT_Y;
		end else begin
			slot_c = SLOT_X;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= mat_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mat_s1  <= mat;
			slot_s1 <= slot_c;
		end
	end

	// Stage 2: radicand and the three dividends
	logic signed [RAD_W-1:0] rad_c;
	side_t                   side_c;
	logic                    valid_s2;
	logic [RAD_U_W-1:0]      rad_s2;
	side_t                   side_s2;

	always_comb begin
		side_c.slot = slot_s1;
		unique case (slot_s1)
			SLOT_W: begin
				rad_c = RAD_W'(mat_s1.m00) + RAD_W'(mat_s1.m11) + RAD_W'(mat_s1.m22) + RAD_ONE;
				side_c.d[0] = dsub(mat_s1.m21, mat_s1.m12);
				side_c.d[1] = dsub(mat_s1.m02, mat_s1.m20);
				side_c.d[2] = dsub(mat_s1.m10, mat_s1.m01);
			end
			SLOT_X: begin
				rad_c = RAD_W'(mat_s1.m00) - RAD_W'(mat_s1.m11) - RAD_W'(mat_s1.m22) + RAD_ONE;
				side_c.d[0] = dsub(mat_s1.m21, mat_s1.m12);
				side_c.d[1] = dadd(mat_s1.m10, mat_s1.m01);
				side_c.d[2] = dadd(mat_s1.m20, mat_s1.m02);
			end
			SLOT_Y: begin
				rad_c = RAD_W'(mat_s1.m11) - RAD_W'(mat_s1.m22) - RAD_W'(mat_s1.m00) + RAD_ONE;
				side_c.d[0] = dsub(mat_s1.m02, mat_s1.m20);
				side_c.d[1] = dadd(mat_s1.m01, mat_s1.m10);
				side_c.d[2] = dadd(mat_s1.m21, mat_s1.m12);
			end
			SLOT_Z: begin
				rad_c = RAD_W'(mat_s1.m22) - RAD_W'(mat_s1.m00) - RAD_W'(mat_s1.m11) + RAD_ONE;
				side_c.d[0] = dsub(mat_s1.m10, mat_s1.m01);
				side_c.d[1] = dadd(mat_s1.m02, mat_s1.m20);
				side_c.d[2] = dadd(mat_s1.m12, mat_s1.m21);
			end
			default: begin
				rad_c  = '0;
				side_c = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			// clamp a non-positive radicand to zero
			rad_s2  <= (rad_c > 0) ? rad_c[RAD_U_W-1:0] : '0;
			side_s2 <= side_c;
		end
	end

	// Square root: one root bit per stage
	logic              sq_vld  [SQ_STEPS];
	logic [ROOT_W-1:0] sq_root [SQ_STEPS];
	logic [REM_W-1:0]  sq_rem  [SQ_STEPS];
	logic [N2_W-1:0]   sq_bits [SQ_STEPS];
	side_t             sq_side [SQ_STEPS];

	genvar t, b;
	generate
		for (t = 0; t < SQ_STEPS; t++) begin : g_sq
			logic              vld_in;
			logic [ROOT_W-1:0] root_in;
			logic [REM_W-1:0]  rem_in;
			logic [N2_W-1:0]   bits_in;
			side_t             side_in;
			logic [ROOT_W+2:0] rsh;
			logic [ROOT_W+2:0] trial;
			logic              ge;

			if (t == 0) begin : g_first
				assign vld_in  = valid_s2;
				assign root_in = '0;
				assign rem_in  = '0;
				assign bits_in = N2_W'(rad_s2) << FRAC_BITS;
				assign side_in = side_s2;
			end else begin : g_next
				assign vld_in  = sq_vld[t-1];
				assign root_in = sq_root[t-1];
				assign rem_in  = sq_rem[t-1];
				assign bits_in = sq_bits[t-1];
				assign side_in = sq_side[t-1];
			end

			assign rsh   = {rem_in, bits_in[N2_W-1 -: 2]};
			assign trial = {1'b0, root_in, 2'b01};
			assign ge    = rsh >= trial;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					sq_vld[t] <= 1'b0;
				end else if (advance) begin
					sq_vld[t] <= vld_in;
				end
			end

			always_ff @(posedge clk) begin
				if (advance) begin
					sq_root[t] <= {root_in[ROOT_W-2:0], ge};
					sq_rem[t]  <= ge ? REM_W'(rsh - trial) : REM_W'(rsh);
					sq_bits[t] <= bits_in << 2;
					sq_side[t] <= side_in;
				end
			end
		end
	endgenerate

	// Round the root to nearest, halve it, take magnitudes of the dividends
	logic [ROOT_W-1:0] s_c;
	logic [ROOT_W:0]   s_inc_c;
	logic              valid_s19;
	logic [ROOT_W-1:0] s_s19;
	logic [ROOT_W-1:0] half_s19;
	logic              zero_s19;
	slot_t             slot_s19;
	logic [N_DIV-1:0]  neg_s19;
	logic [N_DIV-1:0][MAG_W-1:0] mag_s19;

	assign s_c = sq_root[SQ_STEPS-1]
		+ ROOT_W'(sq_rem[SQ_STEPS-1] > {1'b0, sq_root[SQ_STEPS-1]});
	assign s_inc_c = {1'b0, s_c} + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s19 <= 1'b0;
		end else if (advance) begin
			valid_s19 <= sq_vld[SQ_STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			s_s19    <= s_c;
			half_s19 <= s_inc_c[ROOT_W:1];
			zero_s19 <= (s_c == '0);
			slot_s19 <= sq_side[SQ_STEPS-1].slot;
			for (int i = 0; i < N_DIV; i++) begin
				neg_s19[i] <= sq_side[SQ_STEPS-1].d[i][DIFF_W-1];
				mag_s19[i] <= sq_side[SQ_STEPS-1].d[i][DIFF_W-1]
					? (~sq_side[SQ_STEPS-1].d[i]) + 1'b1 : sq_side[SQ_STEPS-1].d[i];
			end
		end
	end

	// Dividend |d| * 2^FRAC_BITS + s, split into first partial remainder and low bits
	logic [N_DIV-1:0][NUM_W-1:0] num_c;
	logic              valid_s20;
	logic [DEN_W-1:0]  den_s20;
	logic [ROOT_W-1:0] half_s20;
	logic              zero_s20;
	slot_t             slot_s20;
	logic [N_DIV-1:0]  neg_s20;
	logic [N_DIV-1:0][DEN_W-1:0] rem_s20;
	logic [N_DIV-1:0][QUO_W-1:0] nq_s20;

	always_comb begin
		for (int i = 0; i < N_DIV; i++) begin
			num_c[i] = {mag_s19[i], {FRAC_BITS{1'b0}}} + NUM_W'(s_s19);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s20 <= 1'b0;
		end else if (advance) begin
			valid_s20 <= valid_s19;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			den_s20  <= {s_s19, 1'b0};
			half_s20 <= half_s19;
			zero_s20 <= zero_s19;
			slot_s20 <= slot_s19;
			neg_s20  <= neg_s19;
			for (int i = 0; i < N_DIV; i++) begin
				rem_s20[i] <= DEN_W'(num_c[i][NUM_W-1:QUO_W]);
				nq_s20[i]  <= num_c[i][QUO_W-1:0];
			end
		end
	end

	// Three restoring dividers, one quotient bit per stage
	logic              dv_vld  [QUO_W];
	logic [DEN_W-1:0]  dv_den  [QUO_W];
	logic [ROOT_W-1:0] dv_half [QUO_W];
	logic              dv_zero [QUO_W];
	slot_t             dv_slot [QUO_W];
	logic [N_DIV-1:0]  dv_neg  [QUO_W];
	logic [DEN_W-1:0]  dv_rem  [QUO_W][N_DIV];
	logic [QUO_W-1:0]  dv_nq   [QUO_W][N_DIV];

	generate
		for (t = 0; t < QUO_W; t++) begin : g_dv
			logic              vld_in;
			logic [DEN_W-1:0]  den_in;
			logic [ROOT_W-1:0] half_in;
			logic              zero_in;
			slot_t             slot_in;
			logic [N_DIV-1:0]  neg_in;

			if (t == 0) begin : g_first
				assign vld_in  = valid_s20;
				assign den_in  = den_s20;
				assign half_in = half_s20;
				assign zero_in = zero_s20;
				assign slot_in = slot_s20;
				assign neg_in  = neg_s20;
			end else begin : g_next
				assign vld_in  = dv_vld[t-1];
				assign den_in  = dv_den[t-1];
				assign half_in = dv_half[t-1];
				assign zero_in = dv_zero[t-1];
				assign slot_in = dv_slot[t-1];
				assign neg_in  = dv_neg[t-1];
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					dv_vld[t] <= 1'b0;
				end else if (advance) begin
					dv_vld[t] <= vld_in;
				end
			end

			always_ff @(posedge clk) begin
				if (advance) begin
					dv_den[t]  <= den_in;
					dv_half[t] <= half_in;
					dv_zero[t] <= zero_in;
					dv_slot[t] <= slot_in;
					dv_neg[t]  <= neg_in;
				end
			end

			for (b = 0; b < N_DIV; b++) begin : g_lane
				logic [DEN_W-1:0] rem_in;
				logic [QUO_W-1:0] nq_in;
				logic [DEN_W:0]   rs;
				logic             ge;

				if (t == 0) begin : g_first
					assign rem_in = rem_s20[b];
					assign nq_in  = nq_s20[b];
				end else begin : g_next
					assign rem_in = dv_rem[t-1][b];
					assign nq_in  = dv_nq[t-1][b];
				end

				assign rs = {rem_in, nq_in[QUO_W-1]};
				assign ge = rs >= {1'b0, den_in};

				always_ff @(posedge clk) begin
					if (advance) begin
						dv_rem[t][b] <= ge ? DEN_W'(rs - {1'b0, den_in}) : rs[DEN_W-1:0];
						dv_nq[t][b]  <= {nq_in[QUO_W-2:0], ge};
					end
				end
			end
		end
	endgenerate

	// Sign, saturate and place the components in their slots
	logic [N_DIV-1:0][DATA_WIDTH-1:0] res_c;
	logic [DATA_WIDTH-1:0]            half_c;
	quat_t                            quat_c;

	always_comb begin
		for (int i = 0; i < N_DIV; i++) begin
			res_c[i] = dv_zero[QUO_W-1] ? '0
				: sat_q(dv_neg[QUO_W-1][i], dv_nq[QUO_W-1][i]);
		end
		half_c = DATA_WIDTH'(dv_half[QUO_W-1]);
		unique case (dv_slot[QUO_W-1])
			SLOT_W: quat_c = {half_c, res_c[0], res_c[1], res_c[2]};
			SLOT_X: quat_c = {res_c[0], half_c, res_c[1], res_c[2]};
			SLOT_Y: quat_c = {res_c[0], res_c[1], half_c, res_c[2]};
			SLOT_Z: quat_c = {res_c[0], res_c[1], res_c[2], half_c};
			default: quat_c = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= dv_vld[QUO_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= quat_c;
		end
	end

endmodule

### rtl/rmq_checker.sv
// Port checker for the rotation matrix to quaternion unit, with its bind
`timescale 1ns / 1ps

`include "rotation_matrix_to_quaternion_unit_assert.svh"

module rmq_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           mat_valid,
	input logic           mat_ready,
	input rmq_pkg::mat_t  mat,
	input logic           quat_valid,
	input logic           quat_ready,
	input rmq_pkg::quat_t quat
);
	import rmq_pkg::*;

	// hold a stalled input item
	`RMQ_ASSERT_HOLD(a_in_hold, clk, arst_n, mat_valid, mat_ready, mat)
	// hold a stalled result item
	`RMQ_ASSERT_HOLD(a_out_hold, clk, arst_n, quat_valid, quat_ready, quat)
	// no result item while in reset
	`RMQ_ASSERT_ALWAYS(a_reset_empty, clk, arst_n || !quat_valid)
	// an empty output register never blocks the input
	`RMQ_ASSERT_IMPL(a_ready_empty, clk, arst_n, !quat_valid, mat_ready)
	// a stalled output stalls the whole pipe
	`RMQ_ASSERT_IMPL(a_stall_input, clk, arst_n, quat_valid && !quat_ready, !mat_ready)

endmodule

bind rotation_matrix_to_quaternion_unit rmq_checker u_rmq_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.mat_valid  (mat_valid),
	.mat_ready  (mat_ready),
	.mat        (mat),
	.quat_valid (quat_valid),
	.quat_ready (quat_ready),
	.quat       (quat)
);

### test/testbench.sv
// Testbench of the rotation matrix to quaternion unit: random and directed matrices
`timescale 1ns / 1ps

module testbench;
	import rmq_pkg::*;

	localparam int N_RANDOM   = 1530;
	localparam int IDLE_LIMIT = 20000;
	localparam int LATENCY    = 44;

	logic   clk = 1'b0;
	logic   arst_n = 1'b1;
	logic   mat_valid = 1'b0;
	logic   mat_ready;
	mat_t   mat = '0;
	logic   quat_valid;
	logic   quat_ready = 1'b0;
	quat_t  quat;

	mat_t   pending_mats[$];
	quat_t  expected_quats[$];
	int     errors = 0;
	int     mats_sent = 0;
	int     quats_seen = 0;
	int     idle_cycles = 0;
	int     send_wait = 0;
	int     take_wait = 0;
	bit     hold_send = 1'b0;
	bit     stim_done = 1'b0;
	int     zero_roots = 0;

	rotation_matrix_to_quaternion_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.mat_valid (mat_valid),
		.mat_ready (mat_ready),
		.mat       (mat),
		.quat_valid(quat_valid),
		.quat_ready(quat_ready),
		.quat      (quat)
	);

	always #4 clk = ~clk;

	function automatic longint fixed_root(longint r);
		longint unsigned n, res, b;
		if (r <= 0)
			return 0;
		n = longint'(r) << FRAC_BITS;
		res = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		if (n > res)
			res++;
		return longint'(res);
	endfunction

	// d / 2s, rounded half away from zero
	function automatic longint scaled_ratio(longint d, longint s);
		longint mag, q;
		if (s == 0)
			return 0;
		mag = d < 0 ? -d : d;
		q = ((mag << FRAC_BITS) + s) / (2 * s);
		return d < 0 ? -q : q;
	endfunction

	function automatic logic signed [DATA_WIDTH-1:0] clamp_q(longint v);
		longint hi, lo;
		hi = (longint'(1) << (DATA_WIDTH - 1)) - 1;
		lo = -(longint'(1) << (DATA_WIDTH - 1));
		if (v > hi) v = hi;
		if (v < lo) v = lo;
		return v[DATA_WIDTH-1:0];
	endfunction

	function automatic quat_t shepperd_quat(mat_t a);
		longint m[3][3];
		longint q[4];
		longint tr, s;
		int i, j, k;
		quat_t res;
		m[0][0] = a.m00; m[0][1] = a.m01; m[0][2] = a.m02;
		m[1][0] = a.m10; m[1][1] = a.m11; m[1][2] = a.m12;
		m[2][0] = a.m20; m[2][1] = a.m21; m[2][2] = a.m22;
		tr = m[0][0] + m[1][1] + m[2][2];
		if (tr > 0) begin
			s = fixed_root(tr + (longint'(1) << FRAC_BITS));
			q[0] = (s + 1) >> 1;
			q[1] = scaled_ratio(m[2][1] - m[1][2], s);
			q[2] = scaled_ratio(m[0][2] - m[2][0], s);
			q[3] = scaled_ratio(m[1][0] - m[0][1], s);
		end else begin
			i = 0;
			if (m[1][1] > m[0][0]) i = 1;
			if (m[2][2] > m[i][i]) i = 2;
			j = (i + 1) % 3;
			k = (j + 1) % 3;
			s = fixed_root(m[i][i] - m[j][j] - m[k][k] + (longint'(1) << FRAC_BITS));
			q[1 + i] = (s + 1) >> 1;
			q[0] = scaled_ratio(m[k][j] - m[j][k], s);
			q[1 + j] = scaled_ratio(m[j][i] + m[i][j], s);
			q[1 + k] = scaled_ratio(m[k][i] + m[i][k], s);
		end
		if (s == 0)
			zero_roots++;
		res.qw = clamp_q(q[SLOT_W]);
		res.qx = clamp_q(q[SLOT_X]);
		res.qy = clamp_q(q[SLOT_Y]);
		res.qz = clamp_q(q[SLOT_Z]);
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [DATA_WIDTH-1:0] got,
			logic [DATA_WIDTH-1:0] want);
		$display("mismatch on %s at item %0d: got %h, expected %h", what, quats_seen, got, want);
		errors++;
	endtask

	function automatic mat_t diag_mat(int a, int b, int c);
		mat_t r;
		r = '0;
		r.m00 = DATA_WIDTH'(a); r.m11 = DATA_WIDTH'(b); r.m22 = DATA_WIDTH'(c);
		return r;
	endfunction

	function automatic logic signed [DATA_WIDTH-1:0] rand_entry();
		case ($urandom_range(0, 5))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return DATA_WIDTH'((int'($urandom_range(0, 32767)) - 16384) >>> 1);
			default: return DATA_WIDTH'($urandom());
		endcase
	endfunction

	// Random matrix: entries in [-1, 1] in most cases, else extreme values or fully random words
	function automatic mat_t rand_mat();
		mat_t r;
		int mode;
		r = '0;
		mode = $urandom_range(0, 9);
		if (mode < 6) begin
			r.m00 = DATA_WIDTH'($urandom_range(0, 32768) - 16384);
			r.m11 = DATA_WIDTH'($urandom_range(0, 32768) - 16384);
			r.m22 = DATA_WIDTH'($urandom_range(0, 32768) - 16384);
			r.m01 = DATA_WIDTH'($urandom_range(0, 32768) - 16384);
			r.m02 = DATA_WIDTH'($urandom_range(0, 32768) - 16384);
			r.m10 = DATA_WIDTH'($urandom_range(0, 32768) - 16384);
			r.m12 = DATA_WIDTH'($urandom_range(0, 32768) - 16384);
			r.m20 = DATA_WIDTH'($urandom_range(0, 32768) - 16384);
			r.m21 = DATA_WIDTH'($urandom_range(0, 32768) - 16384);
		end else if (mode < 8) begin
			r.m00 = rand_entry(); r.m01 = rand_entry(); r.m02 = rand_entry();
			r.m10 = rand_entry(); r.m11 = rand_entry(); r.m12 = rand_entry();
			r.m20 = rand_entry(); r.m21 = rand_entry(); r.m22 = rand_entry();
		end else begin
			r.m00 = DATA_WIDTH'($urandom()); r.m01 = DATA_WIDTH'($urandom());
			r.m02 = DATA_WIDTH'($urandom()); r.m10 = DATA_WIDTH'($urandom());
			r.m11 = DATA_WIDTH'($urandom()); r.m12 = DATA_WIDTH'($urandom());
			r.m20 = DATA_WIDTH'($urandom()); r.m21 = DATA_WIDTH'($urandom());
			r.m22 = DATA_WIDTH'($urandom());
		end
		if ($urandom_range(0, 7) == 0) begin
			// force ties on the diagonal
			r.m11 = r.m00;
			if ($urandom_range(0, 1)) r.m22 = r.m00;
		end
		return r;
	endfunction

	initial begin
		mat_t t;
		#1 arst_n = 1'b0;
		pending_mats.push_back(diag_mat(16384, 16384, 16384));
		pending_mats.push_back(diag_mat(16384, -16384, -16384));
		pending_mats.push_back(diag_mat(-16384, 16384, -16384));
		pending_mats.push_back(diag_mat(-16384, -16384, 16384));
		pending_mats.push_back(diag_mat(0, 0, 0));
		pending_mats.push_back(diag_mat(-16384, -16384, -16384));
		pending_mats.push_back(diag_mat(-32768, -32768, -32768));
		pending_mats.push_back(diag_mat(32767, 32767, 32767));
		pending_mats.push_back(diag_mat(5000, 5000, -20000));
		pending_mats.push_back(diag_mat(-20000, 5000, 5000));
		pending_mats.push_back(diag_mat(-8000, -8000, -8000));
		pending_mats.push_back(diag_mat(0, -16384, 0));
		t = '1;
		pending_mats.push_back(t);
		t = {9{16'sh8000}};
		pending_mats.push_back(t);
		t = {9{16'sh7fff}};
		pending_mats.push_back(t);
		t = diag_mat(1, 0, 0);
		t.m21 = 16'sh7fff; t.m12 = 16'sh8000;
		pending_mats.push_back(t);
		t = diag_mat(-32768, 32767, -32768);
		t.m01 = 16'sh7fff; t.m10 = 16'sh7fff; t.m02 = 16'sh8000; t.m20 = 16'sh8000;
		pending_mats.push_back(t);
		t = diag_mat(0, 0, -1);
		t.m12 = 16'sh7fff; t.m21 = 16'sh7fff;
		pending_mats.push_back(t);
		t = diag_mat(16384, 0, -16384);
		t.m12 = -16'sd16384; t.m21 = 16'sd16384;
		pending_mats.push_back(t);
		for (int n = 0; n < N_RANDOM; n++)
			pending_mats.push_back(rand_mat());
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Sender
	always @(posedge clk) begin
		if (arst_n) begin
			if (mat_valid && mat_ready) begin
				expected_quats.push_back(shepperd_quat(mat));
				mats_sent++;
				if (mats_sent == 800)
					hold_send <= 1'b1;
			end
			if (hold_send && expected_quats.size() == 0 && !(mat_valid && mat_ready))
				hold_send <= 1'b0;
			if (!mat_valid || mat_ready) begin
				if (pending_mats.size() == 0 || hold_send || (mat_valid && mats_sent == 800)) begin
					mat_valid <= 1'b0;
					if (pending_mats.size() == 0)
						stim_done <= 1'b1;
				end else if (send_wait > 0) begin
					mat_valid <= 1'b0;
					send_wait <= send_wait - 1;
				end else begin
					mat <= pending_mats.pop_front();
					mat_valid <= 1'b1;
					send_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
				end
			end
		end
	end

	// Receiver
	always @(posedge clk) begin
		quat_t want;
		int    gap;
		if (arst_n) begin
			if (quat_valid && quat_ready) begin
				quats_seen++;
				if (expected_quats.size() == 0) begin
					$display("unexpected quaternion %h", quat);
					errors++;
				end else begin
					want = expected_quats.pop_front();
					if (quat.qw !== want.qw) report_mismatch("qw", quat.qw, want.qw);
					if (quat.qx !== want.qx) report_mismatch("qx", quat.qx, want.qx);
					if (quat.qy !== want.qy) report_mismatch("qy", quat.qy, want.qy);
					if (quat.qz !== want.qz) report_mismatch("qz", quat.qz, want.qz);
				end
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
				take_wait <= gap;
				// keep ready up for a back-to-back take
				quat_ready <= (gap == 0);
			end else if (take_wait > 0) begin
				take_wait <= take_wait - 1;
				quat_ready <= 1'b0;
			end else begin
				quat_ready <= 1'b1;
			end
		end
	end

	// Watchdog and end of run
	always @(posedge clk) begin
		if ((mat_valid && mat_ready) || (quat_valid && quat_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL rotation_matrix_to_quaternion_unit");
			$finish;
		end
	end

	initial begin
		wait (stim_done && expected_quats.size() == 0);
		repeat (2 * LATENCY) @(posedge clk);
		$display("converted %0d matrices, %0d quaternions checked, %0d with a zero root",
			mats_sent, quats_seen, zero_roots);
		if (errors == 0 && expected_quats.size() == 0)
			$display("PASS rotation_matrix_to_quaternion_unit");
		else
			$display("FAIL rotation_matrix_to_quaternion_unit");
		$finish;
	end

endmodule

### filelist.f
+incdir+rtl
rtl/rmq_pkg.sv
rtl/rotation_matrix_to_quaternion_unit.sv
rtl/rmq_checker.sv
test/testbench.sv
